// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the heading controller.
// Depends on nothing; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define GGH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also runs through reset.
`define GGH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ggh_pkg.sv =====
// Types, constants and the arctangent table of the go-to-goal heading controller.
// Depends on nothing; used by scoped names from the other RTL files.
package ggh_pkg;

   localparam int PosW     = 16;   // Q5.10 positions
   localparam int QuatW    = 16;   // Q1.14 quaternion components
   localparam int GainW    = 16;   // Q4.12 gains
   localparam int LimW     = 15;   // 15 bit unsigned limits
   localparam int LinW     = 15;   // linear velocity
   localparam int AngW     = 16;   // angular velocity
   localparam int ErrW     = 16;   // Q3.12 angles
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 16;

   localparam int CordW    = 38;   // CORDIC x and y
   localparam int ZW       = 28;   // CORDIC angle, 2^-24 rad
   localparam int AtanIdxW = 5;
   localparam int AtanW    = 24;
   localparam int MulW     = 32;
   localparam int ProdW    = 2 * MulW;
   localparam int AccW     = 34;
   localparam int DistW    = 18;

   localparam int AngleShift = 12;  // 2^-24 rad down to Q3.12
   localparam int ScaleShift = 8;   // position difference scaling
   localparam int DistShift  = 38;  // Q0.30 gain plus the scaling
   localparam int LinShift   = 10;
   localparam int PdShift    = 12;
   localparam int PdW        = AccW - PdShift;
   localparam int LinQW      = ProdW - LinShift;

   localparam logic signed [ZW-1:0]     HalfPiA24   = 28'sd26353589;
   localparam logic signed [MulW-1:0]   InvGainQ30  = 32'sd652032875;
   localparam logic signed [ErrW+1:0]   TwoPiQ12    = 18'sd25736;
   localparam logic signed [ZW-1:0]     ZRoundHalf  = ZW'(1) <<< (AngleShift - 1);
   localparam logic signed [ProdW-1:0]  DistHalf    = ProdW'(1) <<< (DistShift - 1);
   localparam logic signed [ProdW-1:0]  LinHalf     = ProdW'(1) <<< (LinShift - 1);
   localparam logic signed [AccW-1:0]   PdHalf      = AccW'(1) <<< (PdShift - 1);

   localparam logic [GainW-1:0] LinearGainRst   = 16'd1229;
   localparam logic [GainW-1:0] HeadingPGainRst = 16'd6144;
   localparam logic [GainW-1:0] HeadingDGainRst = 16'd410;
   localparam logic [LimW-1:0]  LinearLimitRst  = 15'd2048;
   localparam logic [LimW-1:0]  AngularLimitRst = 15'd2048;
   localparam logic [LimW-1:0]  ArriveDistRst   = 15'd51;
   localparam logic [LimW-1:0]  HeadingGateRst  = 15'd532;

   typedef enum logic [CsrAddrW-1:0] {
      CSR_LINEAR_GAIN,
      CSR_HEADING_P_GAIN,
      CSR_HEADING_D_GAIN,
      CSR_LINEAR_LIMIT,
      CSR_ANGULAR_LIMIT,
      CSR_ARRIVE_DISTANCE,
      CSR_HEADING_GATE
   } csr_addr_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_Q_WZ,
      ST_Q_XY,
      ST_Q_WW,
      ST_Q_XX,
      ST_Q_YY,
      ST_Q_ZZ,
      ST_Q_LOAD,
      ST_PREROT,
      ST_ITER,
      ST_B_LOAD,
      ST_DIST,
      ST_WRAP,
      ST_PD_P,
      ST_PD_D,
      ST_PD_LIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic prerot;
      logic step;
   } cordic_ctrl_type;

   // atan(2^-i) in units of 2^-24 rad
   function automatic logic [AtanW-1:0] atan_lut(input logic [AtanIdxW-1:0] idx);
      logic [AtanW-1:0] v;
      case (idx)
         5'd0:  v = 24'd13176795;
         5'd1:  v = 24'd7778716;
         5'd2:  v = 24'd4110060;
         5'd3:  v = 24'd2086331;
         5'd4:  v = 24'd1047214;
         5'd5:  v = 24'd524117;
         5'd6:  v = 24'd262123;
         5'd7:  v = 24'd131069;
         5'd8:  v = 24'd65536;
         5'd9:  v = 24'd32768;
         5'd10: v = 24'd16384;
         5'd11: v = 24'd8192;
         5'd12: v = 24'd4096;
         5'd13: v = 24'd2048;
         5'd14: v = 24'd1024;
         5'd15: v = 24'd512;
         5'd16: v = 24'd256;
         5'd17: v = 24'd128;
         5'd18: v = 24'd64;
         5'd19: v = 24'd32;
         5'd20: v = 24'd16;
         5'd21: v = 24'd8;
         5'd22: v = 24'd4;
         5'd23: v = 24'd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/ggh_if.sv =====
// Channel interfaces of the heading controller: request, response and register write.
// Depends on ggh_pkg for the field widths.
interface ggh_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [ggh_pkg::PosW-1:0]    goal_x;
   logic signed [ggh_pkg::PosW-1:0]    goal_y;
   logic signed [ggh_pkg::PosW-1:0]    robot_x;
   logic signed [ggh_pkg::PosW-1:0]    robot_y;
   logic signed [ggh_pkg::QuatW-1:0]   quat_w;
   logic signed [ggh_pkg::QuatW-1:0]   quat_x;
   logic signed [ggh_pkg::QuatW-1:0]   quat_y;
   logic signed [ggh_pkg::QuatW-1:0]   quat_z;

   modport source (output valid, goal_x, goal_y, robot_x, robot_y,
                   quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, goal_x, goal_y, robot_x, robot_y,
                   quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface ggh_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ggh_pkg::LinW-1:0]         linear_vel;
   logic signed [ggh_pkg::AngW-1:0]  angular_vel;

   modport source (output valid, linear_vel, angular_vel, input ready);
   modport sink   (input valid, linear_vel, angular_vel, output ready);
endinterface

interface ggh_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ggh_pkg::CsrAddrW-1:0]    addr;
   logic [ggh_pkg::CsrDataW-1:0]    wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ===== rtl/ggh_cordic.sv =====
// Shared vectoring CORDIC: quadrant pre-rotation and one micro-rotation per cycle.
// Depends on ggh_pkg for widths, control struct and the arctangent table.
module ggh_cordic #(
   parameter int CORDIC_STEPS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ggh_pkg::cordic_ctrl_type          ctrl,
   input  logic signed [ggh_pkg::CordW-1:0]  x_load,
   input  logic signed [ggh_pkg::CordW-1:0]  y_load,
   output logic signed [ggh_pkg::CordW-1:0]  x_out,
   output logic signed [ggh_pkg::ZW-1:0]     z_out,
   output logic                              last_step
);

   localparam int IterW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

   logic signed [ggh_pkg::CordW-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ggh_pkg::ZW-1:0]    z_ff, z_in, atan_s;
   logic [IterW-1:0]                 iter_ff, iter_in;

   assign xs        = x_ff >>> iter_ff;
   assign ys        = y_ff >>> iter_ff;
   assign atan_s    = signed'(ggh_pkg::ZW'(ggh_pkg::atan_lut(ggh_pkg::AtanIdxW'(iter_ff))));
   assign last_step = (iter_ff == IterW'(CORDIC_STEPS - 1));
   assign x_out     = x_ff;
   assign z_out     = z_ff;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      iter_in = iter_ff;
      if (ctrl.load) begin
         x_in    = x_load;
         y_in    = y_load;
         z_in    = '0;
         iter_in = '0;
      end else if (ctrl.prerot) begin
         iter_in = '0;
         // left half plane: turn by a quarter so x becomes non-negative
         if (x_ff < 0) begin
            if (y_ff >= 0) begin
               x_in = y_ff;
               y_in = -x_ff;
               z_in = ggh_pkg::HalfPiA24;
            end else begin
               x_in = -y_ff;
               y_in = x_ff;
               z_in = -ggh_pkg::HalfPiA24;
            end
         end
      end else if (ctrl.step) begin
         iter_in = iter_ff + IterW'(1);
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_s;
         end else if (y_ff < 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_s;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule

// ===== rtl/ggh_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on ggh_pkg for operand widths.
module ggh_mul (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [ggh_pkg::MulW-1:0]   a,
   input  logic signed [ggh_pkg::MulW-1:0]   b,
   output logic signed [ggh_pkg::ProdW-1:0]  prod
);

   logic signed [ggh_pkg::ProdW-1:0] prod_ff, prod_in;

   assign prod_in = a * b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== rtl/go_to_goal_heading_pd_top.sv =====
// Top level of the go-to-goal heading PD controller: sequencer, registers, datapath.
// Depends on ggh_pkg, ggh_if, ggh_cordic and ggh_mul.
//
// Usage:
//  - req_ch carries one control tick per transaction: goal and robot position (Q5.10)
//    and the orientation quaternion (Q1.14). A transaction is taken when valid and
//    ready are both high; ready is high only while the sequencer is idle.
//  - rsp_ch returns one transaction per tick: linear_vel (Q3.12, never negative) and
//    angular_vel (Q3.12). The result sits in an output register until taken.
//  - csr_ch writes the seven gain and limit registers (index 0 to 6, others are
//    ignored); it is always ready. Write only while no tick is in flight.
//  - Sequence: a tick runs through the single CORDIC unit, which runs twice (yaw,
//    then bearing), and through the one shared multiplier that does six quaternion
//    products, the distance scaling and three PD/linear products. The sequencer goes
//    back to idle when the result is loaded into the output register, so ready comes
//    back up in the same cycle that the result is offered.
//  - If the receiver stalls, the result is held; one more request is taken and runs
//    to its last step, where it waits, and ready stays low until the register frees.
//  - Reset (synchronous, active high) returns to idle, drops any pending result,
//    restores the register defaults and clears the stored heading error.
module go_to_goal_heading_pd_top #(
   parameter int CORDIC_STEPS = 14
) (
   input  logic        clock,
   input  logic        reset,
   ggh_req_if.sink     req_ch,
   ggh_rsp_if.source   rsp_ch,
   ggh_csr_if.sink     csr_ch
);

   ggh_pkg::state_type state_ff, state_in;

   // register file
   logic [ggh_pkg::GainW-1:0] linear_gain_ff, heading_p_gain_ff, heading_d_gain_ff;
   logic [ggh_pkg::LimW-1:0]  linear_limit_ff, angular_limit_ff;
   logic [ggh_pkg::LimW-1:0]  arrive_distance_ff, heading_gate_ff;

   // captured tick
   logic signed [ggh_pkg::PosW-1:0]  goal_x_ff, goal_y_ff, robot_x_ff, robot_y_ff;
   logic signed [ggh_pkg::QuatW-1:0] quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;

   // working registers
   logic                              bearing_ff;
   logic signed [ggh_pkg::AccW-1:0]   num_ff, acc_ff;
   logic signed [ggh_pkg::ErrW-1:0]   yaw_ff, err_ff, last_err_ff;
   logic [ggh_pkg::DistW-1:0]         dist_ff;
   logic                              rsp_valid_ff;
   logic [ggh_pkg::LinW-1:0]          lin_ff;
   logic signed [ggh_pkg::AngW-1:0]   ang_ff;

   // shared units
   ggh_pkg::cordic_ctrl_type          cordic_ctrl;
   logic signed [ggh_pkg::CordW-1:0]  x_load, y_load, cordic_x;
   logic signed [ggh_pkg::ZW-1:0]     cordic_z;
   logic                              cordic_last;
   logic                              mul_en;
   logic signed [ggh_pkg::MulW-1:0]   mul_a, mul_b;
   logic signed [ggh_pkg::ProdW-1:0]  prod;

   logic req_fire, slot_free;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready       = (state_ff == ggh_pkg::ST_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.linear_vel  = lin_ff;
   assign rsp_ch.angular_vel = ang_ff;

   ggh_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (cordic_ctrl),
      .x_load    (x_load),
      .y_load    (y_load),
      .x_out     (cordic_x),
      .z_out     (cordic_z),
      .last_step (cordic_last)
   );

   ggh_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // ---------------------------------------------------------------------------
   // Datapath arithmetic
   // ---------------------------------------------------------------------------
   logic signed [ggh_pkg::AccW-1:0]   prod_lo;
   logic signed [ggh_pkg::ZW-1:0]     z_round;
   logic signed [ggh_pkg::ErrW-1:0]   angle_q12;
   logic signed [ggh_pkg::PosW:0]     dx, dy;
   logic signed [ggh_pkg::ProdW-1:0]  dist_sum, lin_sum;
   logic [ggh_pkg::DistW-1:0]         dist_q;

   // products that feed the accumulators are known to stay inside AccW
   assign prod_lo   = $signed(prod[ggh_pkg::AccW-1:0]);
   assign z_round   = cordic_z + ggh_pkg::ZRoundHalf;
   assign angle_q12 = ggh_pkg::ErrW'(z_round >>> ggh_pkg::AngleShift);
   assign dx        = (ggh_pkg::PosW+1)'(goal_x_ff) - (ggh_pkg::PosW+1)'(robot_x_ff);
   assign dy        = (ggh_pkg::PosW+1)'(goal_y_ff) - (ggh_pkg::PosW+1)'(robot_y_ff);
   assign dist_sum  = prod + ggh_pkg::DistHalf;
   assign dist_q    = ggh_pkg::DistW'(dist_sum >>> ggh_pkg::DistShift);

   // heading error wrap: e, e + 2pi or e - 2pi, whichever is smallest
   logic signed [ggh_pkg::ErrW+1:0] e_raw, c_pos, c_neg, pick_pm, pick;
   logic [ggh_pkg::ErrW+1:0]        mag_e, mag_pos, mag_neg, mag_pm;
   logic signed [ggh_pkg::ErrW-1:0] err_wrap;

   always_comb begin
      e_raw   = (ggh_pkg::ErrW+2)'(yaw_ff) - (ggh_pkg::ErrW+2)'(angle_q12);
      c_pos   = e_raw + ggh_pkg::TwoPiQ12;
      c_neg   = e_raw - ggh_pkg::TwoPiQ12;
      mag_e   = (e_raw < 0) ? unsigned'(-e_raw) : unsigned'(e_raw);
      mag_pos = (c_pos < 0) ? unsigned'(-c_pos) : unsigned'(c_pos);
      mag_neg = (c_neg < 0) ? unsigned'(-c_neg) : unsigned'(c_neg);
      pick_pm = (mag_pos > mag_neg) ? c_neg : c_pos;
      mag_pm  = (mag_pos > mag_neg) ? mag_neg : mag_pos;
      pick    = (mag_e < mag_pm) ? e_raw : pick_pm;
      err_wrap = ggh_pkg::ErrW'(pick);
   end

   // result stage: round, clamp, arrival and heading gate
   logic signed [ggh_pkg::AccW-1:0]  pd_sum;
   logic signed [ggh_pkg::PdW-1:0]   pd_q, pd_lim, pd_clamp;
   logic signed [ggh_pkg::LinQW-1:0] lin_q, lin_lim, lin_clamp;
   logic [ggh_pkg::ErrW-1:0]         err_mag;
   logic                             arrived, gated;
   logic [ggh_pkg::LinW-1:0]         lin_res;
   logic signed [ggh_pkg::AngW-1:0]  ang_res;
   logic signed [ggh_pkg::ErrW-1:0]  last_diff_lo;
   logic signed [ggh_pkg::ErrW:0]    last_diff;

   always_comb begin
      pd_sum  = acc_ff + ggh_pkg::PdHalf;
      pd_q    = ggh_pkg::PdW'(pd_sum >>> ggh_pkg::PdShift);
      pd_lim  = signed'(ggh_pkg::PdW'(angular_limit_ff));
      if (pd_q > pd_lim) begin
         pd_clamp = pd_lim;
      end else if (pd_q < -pd_lim) begin
         pd_clamp = -pd_lim;
      end else begin
         pd_clamp = pd_q;
      end
      lin_sum = prod + ggh_pkg::LinHalf;
      lin_q   = ggh_pkg::LinQW'(lin_sum >>> ggh_pkg::LinShift);
      lin_lim = signed'(ggh_pkg::LinQW'(linear_limit_ff));
      if (lin_q > lin_lim) begin
         lin_clamp = lin_lim;
      end else if (lin_q < 0) begin
         lin_clamp = '0;
      end else begin
         lin_clamp = lin_q;
      end
      err_mag = (err_ff < 0) ? unsigned'(-err_ff) : unsigned'(err_ff);
      arrived = (dist_ff < ggh_pkg::DistW'(arrive_distance_ff));
      gated   = (err_mag > ggh_pkg::ErrW'(heading_gate_ff));
      lin_res = (arrived || gated) ? '0 : ggh_pkg::LinW'(lin_clamp);
      ang_res = arrived ? '0 : ggh_pkg::AngW'(-pd_clamp);
   end

   assign last_diff    = (ggh_pkg::ErrW+1)'(last_err_ff) - (ggh_pkg::ErrW+1)'(err_ff);
   assign last_diff_lo = ggh_pkg::ErrW'(0);

   // ---------------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ggh_pkg::ST_IDLE:   if (req_ch.valid) state_in = ggh_pkg::ST_Q_WZ;
         ggh_pkg::ST_Q_WZ:   state_in = ggh_pkg::ST_Q_XY;
         ggh_pkg::ST_Q_XY:   state_in = ggh_pkg::ST_Q_WW;
         ggh_pkg::ST_Q_WW:   state_in = ggh_pkg::ST_Q_XX;
         ggh_pkg::ST_Q_XX:   state_in = ggh_pkg::ST_Q_YY;
         ggh_pkg::ST_Q_YY:   state_in = ggh_pkg::ST_Q_ZZ;
         ggh_pkg::ST_Q_ZZ:   state_in = ggh_pkg::ST_Q_LOAD;
         ggh_pkg::ST_Q_LOAD: state_in = ggh_pkg::ST_PREROT;
         ggh_pkg::ST_PREROT: state_in = ggh_pkg::ST_ITER;
         ggh_pkg::ST_ITER: begin
            if (cordic_last) begin
               state_in = bearing_ff ? ggh_pkg::ST_DIST : ggh_pkg::ST_B_LOAD;
            end
         end
         ggh_pkg::ST_B_LOAD: state_in = ggh_pkg::ST_PREROT;
         ggh_pkg::ST_DIST:   state_in = ggh_pkg::ST_WRAP;
         ggh_pkg::ST_WRAP:   state_in = ggh_pkg::ST_PD_P;
         ggh_pkg::ST_PD_P:   state_in = ggh_pkg::ST_PD_D;
         ggh_pkg::ST_PD_D:   state_in = ggh_pkg::ST_PD_LIN;
         ggh_pkg::ST_PD_LIN: state_in = ggh_pkg::ST_RESULT;
         ggh_pkg::ST_RESULT: if (slot_free) state_in = ggh_pkg::ST_IDLE;
         default:            state_in = ggh_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Sequencer: unit controls. A product issued in one state is read in the next.
   // ---------------------------------------------------------------------------
   always_comb begin
      mul_en      = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      cordic_ctrl = '0;
      x_load      = '0;
      y_load      = '0;
      case (state_ff)
         ggh_pkg::ST_Q_WZ: begin
            mul_en = 1'b1;
            mul_a  = ggh_pkg::MulW'(quat_w_ff);
            mul_b  = ggh_pkg::MulW'(quat_z_ff);
         end
         ggh_pkg::ST_Q_XY: begin
            mul_en = 1'b1;
            mul_a  = ggh_pkg::MulW'(quat_x_ff);
            mul_b  = ggh_pkg::MulW'(quat_y_ff);
         end
         ggh_pkg::ST_Q_WW: begin
            mul_en = 1'b1;
            mul_a  = ggh_pkg::MulW'(quat_w_ff);
            mul_b  = ggh_pkg::MulW'(quat_w_ff);
         end
         ggh_pkg::ST_Q_XX: begin
            mul_en = 1'b1;
            mul_a  = ggh_pkg::MulW'(quat_x_ff);
            mul_b  = ggh_pkg::MulW'(quat_x_ff);
         end
         ggh_pkg::ST_Q_YY: begin
            mul_en = 1'b1;
            mul_a  = ggh_pkg::MulW'(quat_y_ff);
            mul_b  = ggh_pkg::MulW'(quat_y_ff);
         end
         ggh_pkg::ST_Q_ZZ: begin
            mul_en = 1'b1;
            mul_a  = ggh_pkg::MulW'(quat_z_ff);
            mul_b  = ggh_pkg::MulW'(quat_z_ff);
         end
         ggh_pkg::ST_Q_LOAD: begin
            // x = w^2 + x^2 - y^2 - z^2, y = 2(wz + xy)
            cordic_ctrl.load = 1'b1;
            x_load = ggh_pkg::CordW'(acc_ff - prod_lo);
            y_load = ggh_pkg::CordW'(num_ff) <<< 1;
         end
         ggh_pkg::ST_PREROT: cordic_ctrl.prerot = 1'b1;
         ggh_pkg::ST_ITER:   cordic_ctrl.step   = 1'b1;
         ggh_pkg::ST_B_LOAD: begin
            cordic_ctrl.load = 1'b1;
            x_load = ggh_pkg::CordW'(dx) <<< ggh_pkg::ScaleShift;
            y_load = ggh_pkg::CordW'(dy) <<< ggh_pkg::ScaleShift;
         end
         ggh_pkg::ST_DIST: begin
            // magnitude is non-negative and well inside MulW
            mul_en = 1'b1;
            mul_a  = $signed(cordic_x[ggh_pkg::MulW-1:0]);
            mul_b  = ggh_pkg::InvGainQ30;
         end
         ggh_pkg::ST_PD_P: begin
            mul_en = 1'b1;
            mul_a  = signed'(ggh_pkg::MulW'(heading_p_gain_ff));
            mul_b  = ggh_pkg::MulW'(err_ff);
         end
         ggh_pkg::ST_PD_D: begin
            mul_en = 1'b1;
            mul_a  = signed'(ggh_pkg::MulW'(heading_d_gain_ff));
            mul_b  = ggh_pkg::MulW'(last_diff) + ggh_pkg::MulW'(last_diff_lo);
         end
         ggh_pkg::ST_PD_LIN: begin
            mul_en = 1'b1;
            mul_a  = signed'(ggh_pkg::MulW'(linear_gain_ff));
            mul_b  = signed'(ggh_pkg::MulW'(dist_ff));
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ggh_pkg::ST_IDLE;
         bearing_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ggh_pkg::ST_Q_LOAD) begin
            bearing_ff <= 1'b0;
         end else if (state_ff == ggh_pkg::ST_B_LOAD) begin
            bearing_ff <= 1'b1;
         end
         if (state_ff == ggh_pkg::ST_RESULT && slot_free) begin
            rsp_valid_ff <= 1'b1;
            last_err_ff  <= err_ff;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // register writes; data is masked to the register width
   always_ff @(posedge clock) begin
      if (reset) begin
         linear_gain_ff     <= ggh_pkg::LinearGainRst;
         heading_p_gain_ff  <= ggh_pkg::HeadingPGainRst;
         heading_d_gain_ff  <= ggh_pkg::HeadingDGainRst;
         linear_limit_ff    <= ggh_pkg::LinearLimitRst;
         angular_limit_ff   <= ggh_pkg::AngularLimitRst;
         arrive_distance_ff <= ggh_pkg::ArriveDistRst;
         heading_gate_ff    <= ggh_pkg::HeadingGateRst;
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.addr)
            ggh_pkg::CSR_LINEAR_GAIN:     linear_gain_ff     <= csr_ch.wdata;
            ggh_pkg::CSR_HEADING_P_GAIN:  heading_p_gain_ff  <= csr_ch.wdata;
            ggh_pkg::CSR_HEADING_D_GAIN:  heading_d_gain_ff  <= csr_ch.wdata;
            ggh_pkg::CSR_LINEAR_LIMIT:    linear_limit_ff    <= csr_ch.wdata[ggh_pkg::LimW-1:0];
            ggh_pkg::CSR_ANGULAR_LIMIT:   angular_limit_ff   <= csr_ch.wdata[ggh_pkg::LimW-1:0];
            ggh_pkg::CSR_ARRIVE_DISTANCE: arrive_distance_ff <= csr_ch.wdata[ggh_pkg::LimW-1:0];
            ggh_pkg::CSR_HEADING_GATE:    heading_gate_ff    <= csr_ch.wdata[ggh_pkg::LimW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         goal_x_ff  <= req_ch.goal_x;
         goal_y_ff  <= req_ch.goal_y;
         robot_x_ff <= req_ch.robot_x;
         robot_y_ff <= req_ch.robot_y;
         quat_w_ff  <= req_ch.quat_w;
         quat_x_ff  <= req_ch.quat_x;
         quat_y_ff  <= req_ch.quat_y;
         quat_z_ff  <= req_ch.quat_z;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ggh_pkg::ST_Q_XY:   num_ff <= prod_lo;
         ggh_pkg::ST_Q_WW:   num_ff <= num_ff + prod_lo;
         ggh_pkg::ST_Q_XX:   acc_ff <= prod_lo;
         ggh_pkg::ST_Q_YY:   acc_ff <= acc_ff + prod_lo;
         ggh_pkg::ST_Q_ZZ:   acc_ff <= acc_ff - prod_lo;
         ggh_pkg::ST_B_LOAD: yaw_ff <= angle_q12;   // yaw pass still in the CORDIC
         ggh_pkg::ST_WRAP: begin
            dist_ff <= dist_q;
            err_ff  <= err_wrap;
         end
         ggh_pkg::ST_PD_D:   acc_ff <= prod_lo;
         ggh_pkg::ST_PD_LIN: acc_ff <= acc_ff + prod_lo;
         ggh_pkg::ST_RESULT: begin
            if (slot_free) begin
               lin_ff <= lin_res;
               ang_ff <= ang_res;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/ggh_chk.sv =====
// Port-level checker for the heading controller, bound to the top level.
// Depends on ggh_pkg, assert_macros.svh and go_to_goal_heading_pd_top.
`include "assert_macros.svh"

module ggh_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ggh_pkg::LinW-1:0]          linear_vel,
   input logic signed [ggh_pkg::AngW-1:0]   angular_vel
);

   `GGH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(linear_vel) && $stable(angular_vel), "stalled response changed")
   `GGH_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while a tick is in flight")
   `GGH_ASSERT(a_rsp_from_busy, clock, reset, $rose(rsp_valid) |-> $past(!req_ready), "response without a tick in flight")
   `GGH_ASSERT(a_ang_symmetric, clock, reset, rsp_valid |-> angular_vel != 16'sh8000, "angular velocity outside the symmetric clamp")
   `GGH_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "reset did not return to idle")

endmodule

bind go_to_goal_heading_pd_top ggh_chk u_ggh_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .linear_vel  (rsp_ch.linear_vel),
   .angular_vel (rsp_ch.angular_vel)
);

// ===== sim/ggh_vel_cmd_checker.sv =====
// Velocity command checker for the go-to-goal heading controller.
// Watches the request, response and register channels, predicts each command
// and compares it; depends on ggh_pkg and the channel interfaces in ggh_if.
module ggh_vel_cmd_checker #(
   parameter int CORDIC_STEPS = 14
) (
   input  logic   clock,
   input  logic   reset,
   ggh_req_if     req_mon,
   ggh_rsp_if     rsp_mon,
   ggh_csr_if     csr_mon,
   output int     fail_count,
   output int     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     AtanLen     = 24;
   localparam int     MaxShown    = 10;
   localparam longint HalfPiRad24 = 64'sd26353589;
   localparam longint InvGainQ30  = 64'sd652032875;
   localparam longint TwoPiQ12    = 64'sd25736;
   localparam longint AtanRad24 [AtanLen] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   typedef struct packed {
      logic [ggh_pkg::LinW-1:0] linear_vel;
      logic [ggh_pkg::AngW-1:0] angular_vel;
   } vel_cmd_type;

   vel_cmd_type                cmd_expected [$];
   logic [ggh_pkg::GainW-1:0]  lin_gain, p_gain, d_gain;
   logic [ggh_pkg::LimW-1:0]   lin_limit, ang_limit, arrive_dist, err_gate;
   longint                     prev_heading_err;
   int                         mismatches;

   function automatic longint shr_round(input longint v, input int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint mag_abs(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Vectoring rotation: angle of (x, y) in 2^-24 rad, raw magnitude in mag.
   function automatic longint vector_angle(input longint x_in, input longint y_in,
                                           output longint mag);
      longint x, y, z, xs, ys, t;
      x = x_in;
      y = y_in;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = HalfPiRad24;
         end else begin
            x = -y;
            y = t;
            z = -HalfPiRad24;
         end
      end
      for (int i = 0; i < CORDIC_STEPS && i < AtanLen; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + AtanRad24[i];
         end else if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - AtanRad24[i];
         end
      end
      mag = x;
      return z;
   endfunction

   // Work out one command and advance the stored heading error.
   function automatic vel_cmd_type predict_cmd(
      input logic signed [15:0] gx, gy, rx, ry, qw, qx, qy, qz);
      longint      num, den, unused_mag, mag, yaw, brg, err, wrap_up, wrap_dn, pick;
      longint      dist_q10, pd, lin, ang, dx, dy;
      vel_cmd_type cmd;
      num = 2 * (longint'(qw) * longint'(qz) + longint'(qx) * longint'(qy));
      den = longint'(qw) * longint'(qw) + longint'(qx) * longint'(qx)
            - longint'(qy) * longint'(qy) - longint'(qz) * longint'(qz);
      yaw = shr_round(vector_angle(den, num, unused_mag), 12);

      dx       = longint'(gx) - longint'(rx);
      dy       = longint'(gy) - longint'(ry);
      brg      = shr_round(vector_angle(dx * 256, dy * 256, mag), 12);
      dist_q10 = shr_round(mag * InvGainQ30, 38);

      err     = yaw - brg;
      wrap_up = err + TwoPiQ12;
      wrap_dn = err - TwoPiQ12;
      pick    = (mag_abs(wrap_up) > mag_abs(wrap_dn)) ? wrap_dn : wrap_up;
      if (mag_abs(err) < mag_abs(pick))
         pick = err;
      err = pick;

      pd = shr_round(longint'(p_gain) * err + longint'(d_gain) * (prev_heading_err - err), 12);
      if (pd > longint'(ang_limit))
         pd = longint'(ang_limit);
      if (pd < -longint'(ang_limit))
         pd = -longint'(ang_limit);
      ang = -pd;
      prev_heading_err = err;

      lin = shr_round(dist_q10 * longint'(lin_gain), 10);
      if (lin > longint'(lin_limit))
         lin = longint'(lin_limit);
      if (lin < 0)
         lin = 0;
      if (dist_q10 < longint'(arrive_dist)) begin
         lin = 0;
         ang = 0;
      end
      if (mag_abs(err) > longint'(err_gate))
         lin = 0;

      cmd.linear_vel  = lin[ggh_pkg::LinW-1:0];
      cmd.angular_vel = ang[ggh_pkg::AngW-1:0];
      return cmd;
   endfunction

   always @(posedge clock) begin
      vel_cmd_type want;
      if (reset) begin
         lin_gain         = ggh_pkg::LinearGainRst;
         p_gain           = ggh_pkg::HeadingPGainRst;
         d_gain           = ggh_pkg::HeadingDGainRst;
         lin_limit        = ggh_pkg::LinearLimitRst;
         ang_limit        = ggh_pkg::AngularLimitRst;
         arrive_dist      = ggh_pkg::ArriveDistRst;
         err_gate         = ggh_pkg::HeadingGateRst;
         prev_heading_err = 0;
         mismatches       = 0;
         cmd_expected.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (cmd_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= MaxShown)
                  $display("%0t: unexpected command linear_vel %0d angular_vel %0d",
                           $realtime, rsp_mon.linear_vel, $signed(rsp_mon.angular_vel));
            end else begin
               want = cmd_expected.pop_front();
               if (want.linear_vel !== rsp_mon.linear_vel ||
                   want.angular_vel !== rsp_mon.angular_vel) begin
                  mismatches++;
                  if (mismatches <= MaxShown)
                     $display("%0t: linear_vel exp %0d got %0d, angular_vel exp %0d got %0d",
                              $realtime, want.linear_vel, rsp_mon.linear_vel,
                              $signed(want.angular_vel), $signed(rsp_mon.angular_vel));
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.addr)
               ggh_pkg::CSR_LINEAR_GAIN:     lin_gain    = csr_mon.wdata;
               ggh_pkg::CSR_HEADING_P_GAIN:  p_gain      = csr_mon.wdata;
               ggh_pkg::CSR_HEADING_D_GAIN:  d_gain      = csr_mon.wdata;
               ggh_pkg::CSR_LINEAR_LIMIT:    lin_limit   = csr_mon.wdata[ggh_pkg::LimW-1:0];
               ggh_pkg::CSR_ANGULAR_LIMIT:   ang_limit   = csr_mon.wdata[ggh_pkg::LimW-1:0];
               ggh_pkg::CSR_ARRIVE_DISTANCE: arrive_dist = csr_mon.wdata[ggh_pkg::LimW-1:0];
               ggh_pkg::CSR_HEADING_GATE:    err_gate    = csr_mon.wdata[ggh_pkg::LimW-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            cmd_expected.push_back(predict_cmd(req_mon.goal_x, req_mon.goal_y,
                                               req_mon.robot_x, req_mon.robot_y,
                                               req_mon.quat_w, req_mon.quat_x,
                                               req_mon.quat_y, req_mon.quat_z));
      end
      fail_count <= mismatches;
      pending    <= cmd_expected.size();
   end

endmodule

// ===== sim/tb_go_to_goal_heading_pd_top.sv =====
// Testbench top of the go-to-goal heading controller: clock, reset, stimulus, verdict.
// Depends on ggh_pkg, the channel interfaces in ggh_if, the block itself and
// ggh_vel_cmd_checker, which predicts and compares every command.
module tb_go_to_goal_heading_pd_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     CordicSteps    = 14;
   localparam int     ResetCycles    = 11;
   localparam int     MaxGap         = 14;
   localparam int     BurstLen       = 40;
   localparam int     NumPhases      = 7;
   localparam int     PhaseTicks     = 205;
   localparam int     HoldAfterTicks = 400;
   localparam int     RspHoldCycles  = 800;
   localparam int     EndDrainCycles = 2 * CordicSteps + 27;
   localparam longint TimeoutNs      = 10_000_000;
   localparam real    PiReal         = 3.14159265358979;
   localparam logic [ggh_pkg::CsrAddrW-1:0] CsrUnmapped = 3'd7;
   localparam logic [ggh_pkg::CsrDataW-1:0] AllOnes     = 16'hFFFF;

   // One control tick as it goes onto the request channel.
   typedef struct {
      logic signed [15:0] goal_x, goal_y, robot_x, robot_y;
      logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
   } nav_tick_t;

   logic       clock;
   logic       reset;
   logic       hold_rsp;
   int         fail_count;
   int         pending;
   int         ticks_sent;
   int         gap_max;
   logic [ggh_pkg::CsrDataW-1:0] reg_plan [NumPhases];

   ggh_req_if req_ch ();
   ggh_rsp_if rsp_ch ();
   ggh_csr_if csr_ch ();

   go_to_goal_heading_pd_top #(
      .CORDIC_STEPS (CordicSteps)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ggh_vel_cmd_checker #(
      .CORDIC_STEPS (CordicSteps)
   ) vel_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 10 ns period, first rising edge at 5 ns.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int rand_span(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic logic signed [15:0] to_q14(input real v);
      return 16'($rtoi(v * 16384.0));
   endfunction

   function automatic real rand_angle();
      return real'(rand_span(-31416, 31416)) / 10000.0;
   endfunction

   // Pick one of the corner patterns of a 16 bit signed field.
   function automatic logic signed [15:0] corner_value();
      case ($urandom_range(0, 6))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         4:       return 16'sh0001;
         5:       return 16'sh4000;
         default: return 16'shC000;
      endcase
   endfunction

   // Build a tick whose quaternion is a pure rotation about z, scaled by scale.
   function automatic nav_tick_t tick_from_yaw(input int gx, gy, rx, ry,
                                               input real yaw, input real scale);
      nav_tick_t t;
      t.goal_x  = 16'(gx);
      t.goal_y  = 16'(gy);
      t.robot_x = 16'(rx);
      t.robot_y = 16'(ry);
      t.quat_w  = to_q14(scale * $cos(yaw / 2.0));
      t.quat_x  = '0;
      t.quat_y  = '0;
      t.quat_z  = to_q14(scale * $sin(yaw / 2.0));
      return t;
   endfunction

   // Mostly plausible navigation ticks; the rest is raw noise and corner patterns.
   function automatic nav_tick_t random_tick();
      nav_tick_t t;
      int        kind, rx, ry, ox, oy;
      real       yaw, scale;
      kind  = $urandom_range(0, 99);
      rx    = rand_span(-20000, 20000);
      ry    = rand_span(-20000, 20000);
      scale = 1.0;
      yaw   = rand_angle();
      if (kind < 40) begin
         // heading close to the bearing: straddles the heading gate
         ox  = rand_span(-4000, 4000);
         oy  = rand_span(-4000, 4000);
         yaw = $atan2(real'(oy), real'(ox)) + real'(rand_span(-300, 300)) / 1000.0;
      end else if (kind < 55) begin
         // near the goal: straddles the arrival radius
         ox = rand_span(-100, 100);
         oy = rand_span(-100, 100);
      end else if (kind < 75) begin
         // far goal, any heading, quaternion scaled by 0.1 to 1.0
         ox    = rand_span(-32768, 32767);
         oy    = rand_span(-32768, 32767);
         scale = real'(rand_span(10, 100)) / 100.0;
      end else if (kind < 92) begin
         t.goal_x  = 16'($urandom);
         t.goal_y  = 16'($urandom);
         t.robot_x = 16'($urandom);
         t.robot_y = 16'($urandom);
         t.quat_w  = 16'($urandom);
         t.quat_x  = 16'($urandom);
         t.quat_y  = 16'($urandom);
         t.quat_z  = 16'($urandom);
         return t;
      end else if (kind < 96) begin
         t.goal_x  = corner_value();
         t.goal_y  = corner_value();
         t.robot_x = corner_value();
         t.robot_y = corner_value();
         t.quat_w  = corner_value();
         t.quat_x  = corner_value();
         t.quat_y  = corner_value();
         t.quat_z  = corner_value();
         return t;
      end else begin
         // goal on one axis of the robot, or on the robot itself
         ox = rand_span(-3000, 3000);
         oy = rand_span(-3000, 3000);
         case ($urandom_range(0, 2))
            0:       ox = 0;
            1:       oy = 0;
            default: begin
               ox = 0;
               oy = 0;
            end
         endcase
      end
      t = tick_from_yaw(rx + ox, ry + oy, rx, ry, yaw, scale);
      if (kind < 40 && $urandom_range(0, 3) == 0) begin
         // small roll and pitch on top of the yaw
         t.quat_x = 16'(rand_span(-400, 400));
         t.quat_y = 16'(rand_span(-400, 400));
      end
      return t;
   endfunction

   // Offer one transaction after a random gap and hold it until it is taken.
   // Valid is left high so that a zero gap keeps it up without a drop.
   task automatic send_tick(input nav_tick_t t);
      int gap;
      if (ticks_sent % BurstLen == 0)
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : MaxGap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.goal_x  <= t.goal_x;
      req_ch.goal_y  <= t.goal_y;
      req_ch.robot_x <= t.robot_x;
      req_ch.robot_y <= t.robot_y;
      req_ch.quat_w  <= t.quat_w;
      req_ch.quat_x  <= t.quat_x;
      req_ch.quat_y  <= t.quat_y;
      req_ch.quat_z  <= t.quat_z;
      do @(posedge clock); while (!req_ch.ready);
      ticks_sent++;
   endtask

   task automatic send_raw(input int gx, gy, rx, ry, qw, qx, qy, qz);
      nav_tick_t t;
      t.goal_x  = 16'(gx);
      t.goal_y  = 16'(gy);
      t.robot_x = 16'(rx);
      t.robot_y = 16'(ry);
      t.quat_w  = 16'(qw);
      t.quat_x  = 16'(qx);
      t.quat_y  = 16'(qy);
      t.quat_z  = 16'(qz);
      send_tick(t);
   endtask

   task automatic send_yaw(input int gx, gy, rx, ry, input real yaw);
      send_tick(tick_from_yaw(gx, gy, rx, ry, yaw, 1.0));
   endtask

   // Drop valid and wait until every command in flight has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // Write the planned register set, back to back; optionally poke the unused index.
   task automatic apply_settings(input bit poke_unmapped);
      for (int i = 0; i < NumPhases; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.addr  <= ggh_pkg::csr_addr_type'(i);
         csr_ch.wdata <= reg_plan[i];
         do @(posedge clock); while (!csr_ch.ready);
      end
      if (poke_unmapped) begin
         csr_ch.addr  <= CsrUnmapped;
         csr_ch.wdata <= 16'($urandom);
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Response side: random stall per transaction, bursts with no stall, and the
   // long hold-off below.
   initial begin : rsp_driver
      int stall, stall_max, taken;
      rsp_ch.ready <= 1'b0;
      stall_max = MaxGap;
      taken     = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken % BurstLen == 0)
            stall_max = ($urandom_range(0, 3) == 0) ? 0 : MaxGap;
         stall = $urandom_range(0, stall_max);
         if (stall > 0 || hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            while (hold_rsp)
               @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
      end
   end

   // Hold off the response side for a long stretch mid-run; the request side
   // keeps offering, so the result register fills and ready drops upstream.
   initial begin : rsp_hold
      hold_rsp <= 1'b0;
      wait (ticks_sent >= HoldAfterTicks);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (RspHoldCycles) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin : run_limit
      #(TimeoutNs);
      $display("tb_go_to_goal_heading_pd_top: FAIL");
      $finish;
   end

   initial begin : stimulus
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.goal_x  <= '0;
      req_ch.goal_y  <= '0;
      req_ch.robot_x <= '0;
      req_ch.robot_y <= '0;
      req_ch.quat_w  <= '0;
      req_ch.quat_x  <= '0;
      req_ch.quat_y  <= '0;
      req_ch.quat_z  <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.addr    <= '0;
      csr_ch.wdata   <= '0;
      ticks_sent     = 0;
      gap_max        = MaxGap;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks under the reset register values.
      send_raw(0, 0, 0, 0, 16384, 0, 0, 0);                // goal on the robot
      send_raw(1024, 0, 0, 0, 0, 0, 0, 0);                 // all-zero quaternion
      send_yaw(0, 2048, 0, 0, PiReal / 2.0);               // straight up, aligned
      send_yaw(500, -3000, 500, 0, 0.0);                   // straight down
      send_yaw(-2048, 0, 0, 0, -3.0);                      // bearing pi, error wraps
      send_yaw(2048, 0, 0, 0, 3.0);                        // bearing zero, large error
      send_yaw(-4000, 100, 0, 0, -3.1);                    // error near minus two pi
      send_yaw(-4000, -100, 0, 0, 3.1);                    // error near plus two pi
      send_raw(32767, 32767, -32768, -32768, 16384, 16384, 16384, 16384);
      send_raw(-32768, -32768, 32767, 32767, -32768, -32768, -32768, -32768);
      send_raw(32767, -32768, -32768, 32767, 32767, -32768, 32767, -32768);
      send_yaw(50, 0, 0, 0, 0.0);                          // around the arrival radius
      send_yaw(51, 0, 0, 0, 0.0);
      send_yaw(52, 0, 0, 0, 0.0);
      send_yaw(2048, 0, 0, 0, 0.129);                      // around the heading gate
      send_yaw(2048, 0, 0, 0, 0.131);
      send_raw(3000, 3000, 0, 0, 0, 16384, 0, 0);          // pure roll
      send_raw(-3000, 3000, 0, 0, 0, 0, 16384, 0);         // pure pitch, yaw pi
      send_raw(0, -3000, 0, 0, 0, 0, 0, -16384);
      send_raw(1, 0, 0, 0, 16384, 0, 0, 0);                // smallest offsets
      send_raw(0, -1, 0, 0, 16384, 0, 0, 0);
      send_raw(0, 0, -7000, 9000, 11585, 0, 0, -11585);    // goal at origin

      // Random phases, each under its own register set. Masking of the 15 bit
      // registers is exercised by writing all ones.
      for (int p = 0; p < NumPhases; p++) begin
         drain();
         case (p)
            0: begin
               for (int i = 0; i < NumPhases; i++)
                  reg_plan[i] = 16'($urandom);
            end
            1: begin
               for (int i = 0; i < NumPhases; i++)
                  reg_plan[i] = '0;
            end
            2: begin
               for (int i = 0; i < NumPhases; i++)
                  reg_plan[i] = AllOnes;
            end
            3: begin
               reg_plan[ggh_pkg::CSR_LINEAR_GAIN]     = ggh_pkg::LinearGainRst;
               reg_plan[ggh_pkg::CSR_HEADING_P_GAIN]  = ggh_pkg::HeadingPGainRst;
               reg_plan[ggh_pkg::CSR_HEADING_D_GAIN]  = ggh_pkg::HeadingDGainRst;
               reg_plan[ggh_pkg::CSR_LINEAR_LIMIT]    = 16'(ggh_pkg::LinearLimitRst);
               reg_plan[ggh_pkg::CSR_ANGULAR_LIMIT]   = 16'(ggh_pkg::AngularLimitRst);
               reg_plan[ggh_pkg::CSR_ARRIVE_DISTANCE] = 16'(ggh_pkg::ArriveDistRst);
               reg_plan[ggh_pkg::CSR_HEADING_GATE]    = 16'(ggh_pkg::HeadingGateRst);
            end
            5: begin
               reg_plan[ggh_pkg::CSR_LINEAR_GAIN]     = AllOnes;
               reg_plan[ggh_pkg::CSR_HEADING_P_GAIN]  = '0;
               reg_plan[ggh_pkg::CSR_HEADING_D_GAIN]  = AllOnes;
               reg_plan[ggh_pkg::CSR_LINEAR_LIMIT]    = AllOnes;
               reg_plan[ggh_pkg::CSR_ANGULAR_LIMIT]   = 16'($urandom_range(0, 32767));
               reg_plan[ggh_pkg::CSR_ARRIVE_DISTANCE] = '0;
               reg_plan[ggh_pkg::CSR_HEADING_GATE]    = AllOnes;
            end
            default: begin
               // moderate random gains and limits
               reg_plan[ggh_pkg::CSR_LINEAR_GAIN]     = 16'($urandom);
               reg_plan[ggh_pkg::CSR_HEADING_P_GAIN]  = 16'($urandom_range(0, 16384));
               reg_plan[ggh_pkg::CSR_HEADING_D_GAIN]  = 16'($urandom_range(0, 8192));
               reg_plan[ggh_pkg::CSR_LINEAR_LIMIT]    = 16'($urandom_range(0, 32767));
               reg_plan[ggh_pkg::CSR_ANGULAR_LIMIT]   = 16'($urandom_range(0, 32767));
               reg_plan[ggh_pkg::CSR_ARRIVE_DISTANCE] = 16'($urandom_range(0, 200));
               reg_plan[ggh_pkg::CSR_HEADING_GATE]    = 16'($urandom_range(100, 4000));
            end
         endcase
         apply_settings(p == 3);
         for (int n = 0; n < PhaseTicks; n++)
            send_tick(random_tick());
      end

      // Wait out the last commands, then give the verdict.
      drain();
      repeat (EndDrainCycles) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_go_to_goal_heading_pd_top: PASS");
      end else begin
         $display("tb_go_to_goal_heading_pd_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ggh_pkg.sv
rtl/ggh_if.sv
rtl/ggh_cordic.sv
rtl/ggh_mul.sv
rtl/go_to_goal_heading_pd_top.sv
rtl/ggh_chk.sv
sim/ggh_vel_cmd_checker.sv
sim/tb_go_to_goal_heading_pd_top.sv
